>>> rtl/swt_pkg.sv
// Package for the shell word tokenizer: item and result types, result kinds,
// character codes and the default word-count limit.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package swt_pkg;

	localparam int unsigned MAX_WORDS_DEF = 255;

	// Character codes the tokenizer reacts to.
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_WORD_END = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic [7:0] word_count;
	} result_t;

	// All results caused by one item, slot 0 first.
	typedef struct packed {
		logic [1:0]       cnt;
		result_t [2:0]    res;
	} bundle_t;

	// Status of the output buffer as seen by the input side.
	typedef struct packed {
		logic valid;
		logic done;
	} buf_status_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

>>> rtl/swt_core.sv
// Tokenizer state and the single-pass step logic for one registered item.
// Depends on swt_pkg.
`default_nettype none

module swt_core #(
	parameter int unsigned MAX_WORDS = swt_pkg::MAX_WORDS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire swt_pkg::item_t  item,
	input  wire logic            step_en,
	output swt_pkg::bundle_t     bundle
);
	import swt_pkg::*;

	localparam logic [7:0] CountLimit = (MAX_WORDS < 255) ? 8'(MAX_WORDS) : 8'd255;

	logic       in_word_q, sq_q, dq_q, esc_q;
	logic [7:0] words_q;
	logic       in_word_d, sq_d, dq_d, esc_d;
	logic [7:0] words_d;
	logic [7:0] words_inc;
	logic [7:0] esc_byte;
	logic [1:0] k;
	bundle_t    bnd;

	always_comb begin
		in_word_d = in_word_q;
		sq_d      = sq_q;
		dq_d      = dq_q;
		esc_d     = esc_q;
		words_d   = words_q;
		bnd       = '0;
		k         = '0;
		words_inc = (words_q < CountLimit) ? words_q + 8'd1 : words_q;
		if (item.ch == CH_LOWER_N) begin
			esc_byte = CH_LF;
		end else if (item.ch == CH_LOWER_T) begin
			esc_byte = CH_TAB;
		end else begin
			esc_byte = item.ch;
		end

		if (item.cmd) begin
			// A dangling backslash comes out as itself before the word closes.
			if (esc_q) begin
				bnd.res[k] = '{kind: KIND_BYTE, out_byte: CH_BSLASH, word_count: words_q};
				k = k + 2'd1;
			end
			if (in_word_q) begin
				words_d = words_inc;
				bnd.res[k] = '{kind: KIND_WORD_END, out_byte: 8'd0, word_count: words_inc};
				k = k + 2'd1;
			end
			bnd.res[k] = '{kind: KIND_LINE_END, out_byte: 8'd0, word_count: words_d};
			k = k + 2'd1;
			in_word_d = 1'b0;
			sq_d      = 1'b0;
			dq_d      = 1'b0;
			esc_d     = 1'b0;
			words_d   = '0;
		end else if (esc_q) begin
			esc_d = 1'b0;
			bnd.res[0] = '{kind: KIND_BYTE, out_byte: esc_byte, word_count: words_q};
			k = 2'd1;
		end else if (!sq_q && !dq_q && is_blank(item.ch)) begin
			if (in_word_q) begin
				in_word_d = 1'b0;
				words_d   = words_inc;
				bnd.res[0] = '{kind: KIND_WORD_END, out_byte: 8'd0, word_count: words_inc};
				k = 2'd1;
			end
		end else if (!dq_q && item.ch == CH_SQUOTE) begin
			sq_d      = !sq_q;
			in_word_d = 1'b1;
		end else if (!sq_q && item.ch == CH_DQUOTE) begin
			dq_d      = !dq_q;
			in_word_d = 1'b1;
		end else if (!sq_q && item.ch == CH_BSLASH) begin
			esc_d     = 1'b1;
			in_word_d = 1'b1;
		end else begin
			in_word_d = 1'b1;
			bnd.res[0] = '{kind: KIND_BYTE, out_byte: item.ch, word_count: words_q};
			k = 2'd1;
		end
		bnd.cnt = k;
	end

	assign bundle = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			sq_q      <= 1'b0;
			dq_q      <= 1'b0;
			esc_q     <= 1'b0;
			words_q   <= '0;
		end else if (step_en) begin
			in_word_q <= in_word_d;
			sq_q      <= sq_d;
			dq_q      <= dq_d;
			esc_q     <= esc_d;
			words_q   <= words_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/swt_out_buf.sv
// Result register of the tokenizer: holds the results of one item and hands
// them out one per request. Depends on swt_pkg.
`default_nettype none

module swt_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire swt_pkg::bundle_t  bundle_in,
	input  wire logic              ready,
	output swt_pkg::result_t       result,
	output logic                   last,
	output swt_pkg::buf_status_t   status
);
	import swt_pkg::*;

	bundle_t    bnd_s2;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       at_last;

	assign at_last       = (idx_q == bnd_s2.cnt - 2'd1);
	assign result        = bnd_s2.res[idx_q];
	assign last          = at_last;
	assign status.valid  = valid_q;
	assign status.done   = valid_q && ready && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && ready) begin
			valid_q <= !at_last;
			idx_q   <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_s2 <= bundle_in;
		end
	end

endmodule

`default_nettype wire

>>> rtl/shell_word_tokenizer.sv
// Shell word tokenizer: a request passes the input register stage, then the result register.
// Throughput is one input request per cycle while each yields at most one result and the
// output is ready; an item with more results holds the single result register until all are out.
// Asynchronous active-low reset clears the quoting, escape, word and count state and
// empties the input and result stages. Top level; depends on swt_pkg, swt_core, swt_out_buf.
`default_nettype none

module shell_word_tokenizer #(
	parameter int unsigned MAX_WORDS = swt_pkg::MAX_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	input  wire logic        s_tuser,   // [0] cmd: 0 = line byte, 1 = end of line
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [15:8] word_count
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // final result of one input request
);
	import swt_pkg::*;

	// Input register stage. An item sits here while its results are worked out
	// from the current tokenizer state in one combinational pass.
	logic        valid_s1;
	item_t       item_s1;
	logic        adv;
	logic        load;
	bundle_t     bundle;
	buf_status_t st;
	result_t     res;
	logic        res_last;

	// The registered item moves on when it yields no result, or when the result
	// register is empty or hands out its final result in this very cycle.
	assign adv      = valid_s1 && ((bundle.cnt == 2'd0) || !st.valid || st.done);
	assign load     = adv && (bundle.cnt != 2'd0);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{cmd: s_tuser, ch: s_tdata};
		end
	end

	// Tokenizer state and step logic; the state commits when the item moves on.
	swt_core #(
		.MAX_WORDS(MAX_WORDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.step_en (adv),
		.bundle  (bundle)
	);

	// Result register with a small serializer for items that yield several results.
	swt_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle_in (bundle),
		.ready     (m_tready),
		.result    (res),
		.last      (res_last),
		.status    (st)
	);

	assign m_tvalid = st.valid;
	assign m_tdata  = {res.word_count, res.out_byte};
	assign m_tuser  = res.kind;
	assign m_tlast  = res_last;

	// A line end is always the final result of its request.
	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_LINE_END) |-> m_tlast)
		else $error("line-end result not marked last");

	// A closed word has been counted, so its count is never zero.
	a_word_end_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_WORD_END) |-> (m_tdata[15:8] != 8'd0))
		else $error("word end reported with zero count");

	// Only byte results carry a byte.
	a_byte_unused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_BYTE) |-> (m_tdata[7:0] == 8'd0))
		else $error("non-byte result carries a byte");

	// An item held in the input stage is not dropped before it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input stage lost an item");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for shell_word_tokenizer: directed lines, a word-count saturation line
// and random well-formed lines mixed with noise, with random idling on both stream sides.
// Depends on swt_pkg and the shell_word_tokenizer RTL only.
`timescale 1ns / 100ps

module testbench;

	import swt_pkg::*;

	localparam int unsigned WORD_LIMIT = (MAX_WORDS_DEF > 255) ? 255 : MAX_WORDS_DEF;
	localparam int MAX_GAP = 12;
	localparam int RANDOM_REQUESTS = 470;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 400000;

	// One expected result: the three output fields plus the end-of-request flag.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic [7:0] word_count;
		logic       last;
	} token_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Tokenizer state as the bench predicts it.
	logic       word_open;
	logic       in_squote;
	logic       in_dquote;
	logic       escape_pending;
	logic [7:0] word_tally;

	token_t expected_tokens[$];
	int     failures;
	int     requests_sent;
	int     cycle_count;
	int     tx_max_gap;
	int     rx_max_gap;
	int     rx_hold;

	shell_word_tokenizer #(
		.MAX_WORDS(MAX_WORDS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor. Each accepted request is run through this copy of the
	// tokenizer state and its results are queued in order, the final one
	// of the request flagged as last.
	// ------------------------------------------------------------------
	function automatic token_t make_token(input kind_t k, input logic [7:0] b);
		token_t t;
		t.kind = k;
		t.out_byte = b;
		t.word_count = word_tally;
		t.last = 1'b0;
		return t;
	endfunction

	// Closing a word bumps the tally first, so the word-end result already
	// counts the word it ends. The tally sticks at the limit.
	function automatic token_t close_word();
		word_open = 1'b0;
		if (word_tally < WORD_LIMIT)
			word_tally = word_tally + 8'd1;
		return make_token(KIND_WORD_END, 8'h00);
	endfunction

	function automatic void clear_tokenizer();
		word_open = 1'b0;
		in_squote = 1'b0;
		in_dquote = 1'b0;
		escape_pending = 1'b0;
		word_tally = 8'd0;
	endfunction

	function automatic void tokenize_request(input logic cmd, input logic [7:0] ch);
		token_t toks [3];
		int n;
		logic [7:0] c;
		logic blank;
		n = 0;
		c = ch;
		blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		if (cmd) begin
			// A backslash still waiting at end of line is kept as a plain byte.
			if (escape_pending) begin
				toks[n] = make_token(KIND_BYTE, CH_BSLASH);
				n++;
			end
			// Open quotes do not matter here: the word closes as it stands.
			if (word_open) begin
				toks[n] = close_word();
				n++;
			end
			toks[n] = make_token(KIND_LINE_END, 8'h00);
			n++;
			clear_tokenizer();
		end else if (escape_pending) begin
			escape_pending = 1'b0;
			if (c == CH_LOWER_N)
				c = CH_LF;
			else if (c == CH_LOWER_T)
				c = CH_TAB;
			toks[n] = make_token(KIND_BYTE, c);
			n++;
		end else if (!in_squote && !in_dquote && blank) begin
			if (word_open) begin
				toks[n] = close_word();
				n++;
			end
		end else if (!in_dquote && c == CH_SQUOTE) begin
			in_squote = ~in_squote;
			word_open = 1'b1;
		end else if (!in_squote && c == CH_DQUOTE) begin
			in_dquote = ~in_dquote;
			word_open = 1'b1;
		end else if (!in_squote && c == CH_BSLASH) begin
			escape_pending = 1'b1;
			word_open = 1'b1;
		end else begin
			word_open = 1'b1;
			toks[n] = make_token(KIND_BYTE, c);
			n++;
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				toks[i].last = 1'b1;
			expected_tokens.push_back(toks[i]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor and checker. Everything is sampled at the rising edge, while
	// inputs only move at the falling edge, so no race is possible. Input
	// requests are predicted before results are checked in the same edge.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, exp_val, act_val);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		token_t exp_tok;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding",
				$time, expected_tokens.size());
			$display("testbench: FAIL");
			$finish;
		end else begin
			if (s_tvalid && s_tready)
				tokenize_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				rx_hold = int'($urandom_range(0, rx_max_gap));
				if (expected_tokens.size() == 0) begin
					$display({"%0t ns: unexpected result, expected none, ",
						"actual kind %0d byte %0d count %0d last %0d"},
						$time, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
					failures++;
				end else begin
					exp_tok = expected_tokens.pop_front();
					check_field("kind", int'(exp_tok.kind), int'(m_tuser));
					check_field("out_byte", int'(exp_tok.out_byte), int'(m_tdata[7:0]));
					check_field("word_count", int'(exp_tok.word_count),
						int'(m_tdata[15:8]));
					check_field("last", int'(exp_tok.last), int'(m_tlast));
				end
			end
		end
	end

	// Result side back-pressure: after each accepted result the receiver
	// holds tready low for a drawn number of cycles.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready = 1'b0;
		end else if (rx_hold > 0) begin
			m_tready = 1'b0;
			rx_hold--;
		end else begin
			m_tready = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Request driver. Called at a falling edge and returns at one, with
	// tvalid still high; an idle gap lowers it only when one is drawn, so
	// back-to-back requests never see tvalid drop and rise in one step.
	// ------------------------------------------------------------------
	task automatic send_item(input logic cmd, input logic [7:0] ch);
		int gap;
		gap = int'($urandom_range(0, tx_max_gap));
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = ch;
		s_tuser = cmd;
		do
			@(posedge clk);
		while (!s_tready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_item(1'b0, text[i]);
	endtask

	task automatic end_line();
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------

	// End of line with nothing before it reports a count of zero; the
	// byte that rides along with it must be ignored.
	task automatic test_empty_line();
		send_item(1'b1, 8'hFF);
	endtask

	// Byte extremes are ordinary word bytes, and every blank in the range
	// 0x09 to 0x0D, as well as space, splits words.
	task automatic test_raw_bytes();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h0B);
		send_item(1'b0, 8'h80);
		send_item(1'b0, 8'h0C);
		send_item(1'b0, 8'h0D);
		send_item(1'b0, 8'h7F);
		send_item(1'b0, CH_LF);
		send_item(1'b0, CH_TAB);
		send_item(1'b0, CH_SPACE);
		send_item(1'b1, 8'h00);
	endtask

	// Empty quote pairs still make words; a quote of one kind inside the
	// other kind is plain data.
	task automatic test_quoting();
		send_text("'' \"\" \"a'b\" 'c\"d'e");
		end_line();
	endtask

	// Escapes: n and t are translated, escaped quotes, blanks and
	// backslashes are plain, backslash inside single quotes is literal,
	// and escapes still work inside double quotes.
	task automatic test_escapes();
		send_text("\\n\\t\\'\\\"\\ \\\\x '\\' \"\\\"\\n\"");
		send_item(1'b0, CH_BSLASH);
		send_item(1'b0, 8'h00);
		end_line();
	endtask

	// Line endings with open state: an unterminated quote, then a
	// dangling backslash, then a dangling backslash that opens the word.
	task automatic test_line_end_cases();
		send_text("ab 'cd");
		end_line();
		send_text("\"x\\");
		end_line();
		send_item(1'b0, CH_BSLASH);
		end_line();
	endtask

	// More words than the counter holds: the count sticks at its limit
	// while further words are still split and reported. Runs with no
	// idling on either side.
	task automatic test_count_limit();
		tx_max_gap = 0;
		rx_max_gap = 0;
		for (int i = 0; i < WORD_LIMIT + 5; i++) begin
			send_item(1'b0, 8'(8'h61 + (i % 26)));
			send_item(1'b0, CH_SPACE);
		end
		send_text("tail");
		end_line();
		tx_max_gap = MAX_GAP;
		rx_max_gap = MAX_GAP;
	endtask

	// ------------------------------------------------------------------
	// Random traffic: mostly lines built from a shell-like alphabet with
	// quotes, blanks and escapes, some bursts of raw noise with random
	// line ends. The idle settings change from line to line.
	// ------------------------------------------------------------------
	function automatic logic [7:0] shell_like_byte();
		int pick;
		logic [7:0] blanks [6];
		blanks = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
		pick = int'($urandom_range(0, 99));
		if (pick < 40)
			return 8'(8'h61 + $urandom_range(0, 25));
		else if (pick < 55)
			return blanks[$urandom_range(0, 5)];
		else if (pick < 65)
			return CH_SQUOTE;
		else if (pick < 75)
			return CH_DQUOTE;
		else if (pick < 85)
			return CH_BSLASH;
		else if (pick < 90)
			return ($urandom_range(0, 1) == 0) ? CH_LOWER_N : CH_LOWER_T;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_random_traffic();
		int stop_at;
		int len;
		stop_at = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < stop_at) begin
			tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			if ($urandom_range(0, 4) == 0) begin
				len = int'($urandom_range(1, 10));
				repeat (len)
					send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
			end else begin
				len = int'($urandom_range(0, 24));
				repeat (len)
					send_item(1'b0, shell_like_byte());
				end_line();
			end
		end
		tx_max_gap = MAX_GAP;
		rx_max_gap = MAX_GAP;
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		failures = 0;
		requests_sent = 0;
		cycle_count = 0;
		rx_hold = 0;
		tx_max_gap = MAX_GAP;
		rx_max_gap = MAX_GAP;
		clear_tokenizer();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_line();
		test_raw_bytes();
		test_quoting();
		test_escapes();
		test_line_end_cases();
		test_count_limit();
		test_random_traffic();

		s_tvalid = 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
